// File: rtl/ehc_pkg.sv
// Shared types, codes and constants for the exposure hill-climb tuner.
// No dependencies; imported by every module of the block.
package ehc_pkg;

  localparam int SCORE_W = 15;
  localparam int ITER_W  = 8;
  localparam int EXPO_W  = 11;
  localparam int GAIN_W  = 5;
  localparam int SET_W   = 3;
  localparam int PROD_W  = 2 * SCORE_W;

  // request codes
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_METRICS = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_QUALITY_TARGET  = 2'd0;
  localparam logic [1:0] CFG_MIN_IMPROVEMENT = 2'd1;
  localparam logic [1:0] CFG_MAX_ITERATIONS  = 2'd2;

  localparam logic [SCORE_W-1:0] QUALITY_TARGET_RST  = 15'd19200;
  localparam logic [SCORE_W-1:0] MIN_IMPROVEMENT_RST = 15'd512;
  localparam logic [ITER_W-1:0]  MAX_ITERATIONS_RST  = 8'd10;

  // neighbor step choice
  localparam logic [1:0] SEL_BRIGHT = 2'd0;
  localparam logic [1:0] SEL_CONTR  = 2'd1;
  localparam logic [1:0] SEL_GAIN   = 2'd2;
  localparam logic [1:0] SEL_EXPO   = 2'd3;

  // classification thresholds, 1/256 units
  localparam logic [SCORE_W-1:0] UNDER_LIMIT    = 15'd3840;
  localparam logic [SCORE_W-1:0] OVER_LIMIT     = 15'd2560;
  localparam logic [SCORE_W-1:0] CONTRAST_FLOOR = 15'd7680;
  localparam logic [SCORE_W-1:0] NOISE_LIMIT    = 15'd7680;

  // 100 percent in 1/256 units
  localparam logic [PROD_W-1:0] IMPROVE_SCALE = 30'd25600;

  // setting limits and steps
  localparam logic [EXPO_W-1:0] EXPO_MAX        = 11'd1200;
  localparam logic [EXPO_W-1:0] EXPO_DEFAULT    = 11'd300;
  localparam logic [EXPO_W-1:0] EXPO_DARK_STEP  = 11'd200;
  localparam logic [EXPO_W-1:0] EXPO_BRIGHT_MIN = 11'd100;
  localparam logic [EXPO_W-1:0] EXPO_NOISE_MAX  = 11'd800;
  localparam logic [EXPO_W-1:0] EXPO_NOISE_STEP = 11'd100;
  localparam logic [GAIN_W-1:0] GAIN_MAX        = 5'd30;
  localparam logic [GAIN_W-1:0] GAIN_DARK_MAX   = 5'd20;
  localparam logic [GAIN_W-1:0] GAIN_DARK_STEP  = 5'd5;
  localparam logic [GAIN_W-1:0] GAIN_NOISE_STEP = 5'd3;
  localparam int                GAIN_RAND_STEP  = 3;
  localparam int                EXPO_RAND_STEP  = 50;
  localparam logic signed [SET_W-1:0] SET_MIN   = -3'sd2;
  localparam logic signed [SET_W-1:0] SET_MAX   = 3'sd2;

  typedef enum logic [2:0] {
    ISS_NONE     = 3'd0,
    ISS_DARK     = 3'd1,
    ISS_BRIGHT   = 3'd2,
    ISS_CONTRAST = 3'd3,
    ISS_NOISE    = 3'd4
  } issue_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_ITER  = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed [SET_W-1:0] bright;
    logic signed [SET_W-1:0] contr;
    logic signed [SET_W-1:0] sharp;
    logic [GAIN_W-1:0]       gain;
    logic [EXPO_W-1:0]       expo;
    logic                    flash;
  } cam_set_t;

  localparam cam_set_t SET_RESET = '{bright: 3'sd0, contr: 3'sd0, sharp: 3'sd0,
                                     gain: 5'd0, expo: EXPO_DEFAULT, flash: 1'b0};

  typedef struct packed {
    logic               is_dark;
    logic               is_bright;
    logic [SCORE_W-1:0] under_exposure;
    logic [SCORE_W-1:0] over_exposure;
    logic [SCORE_W-1:0] contrast_level;
    logic [SCORE_W-1:0] noise_level;
  } metrics_t;

  typedef struct packed {
    logic               req_type;
    metrics_t           metrics;
    logic [SCORE_W-1:0] frame_score;
    logic signed [1:0]  rand_step;
    logic [1:0]         rand_param;
  } item_t;

endpackage

// File: rtl/ehc_classify.sv
// Frame issue classifier: dark, bright, low contrast, noise, in that priority.
// Depends on ehc_pkg.
module ehc_classify
  import ehc_pkg::*;
(
  input  metrics_t metrics,
  output issue_t   issue
);

  always_comb begin
    priority if (metrics.is_dark || metrics.under_exposure > UNDER_LIMIT) begin
      issue = ISS_DARK;
    end else if (metrics.is_bright || metrics.over_exposure > OVER_LIMIT) begin
      issue = ISS_BRIGHT;
    end else if (metrics.contrast_level < CONTRAST_FLOOR) begin
      issue = ISS_CONTRAST;
    end else if (metrics.noise_level > NOISE_LIMIT) begin
      issue = ISS_NOISE;
    end else begin
      issue = ISS_NONE;
    end
  end

endmodule

// File: rtl/ehc_next_cand.sv
// Next candidate settings: clamped fix for the issue, or a random neighbor step.
// Depends on ehc_pkg.
module ehc_next_cand
  import ehc_pkg::*;
(
  input  cam_set_t          cur,
  input  issue_t            issue,
  input  logic signed [1:0] rand_step,
  input  logic [1:0]        rand_param,
  output cam_set_t          nxt
);

  logic signed [SET_W:0]    b_sum;
  logic signed [SET_W:0]    c_sum;
  logic signed [6:0]        g_sum;
  logic signed [12:0]       e_sum;
  logic [EXPO_W:0]          expo_up;
  logic [EXPO_W:0]          expo_nup;
  logic [GAIN_W:0]          gain_up;
  logic signed [SET_W-1:0]  b_clamp;
  logic signed [SET_W-1:0]  c_clamp;
  logic [GAIN_W-1:0]        g_clamp;
  logic [EXPO_W-1:0]        e_clamp;

  assign b_sum    = (SET_W + 1)'(cur.bright) + (SET_W + 1)'(rand_step);
  assign c_sum    = (SET_W + 1)'(cur.contr) + (SET_W + 1)'(rand_step);
  assign g_sum    = $signed({2'b00, cur.gain}) + 7'(rand_step) * 7'(GAIN_RAND_STEP);
  assign e_sum    = $signed({2'b00, cur.expo}) + 13'(rand_step) * 13'(EXPO_RAND_STEP);
  assign expo_up  = {1'b0, cur.expo} + {1'b0, EXPO_DARK_STEP};
  assign expo_nup = {1'b0, cur.expo} + {1'b0, EXPO_NOISE_STEP};
  assign gain_up  = {1'b0, cur.gain} + {1'b0, GAIN_DARK_STEP};

  always_comb begin
    if (b_sum < (SET_W + 1)'(SET_MIN))      b_clamp = SET_MIN;
    else if (b_sum > (SET_W + 1)'(SET_MAX)) b_clamp = SET_MAX;
    else                                    b_clamp = b_sum[SET_W-1:0];
    if (c_sum < (SET_W + 1)'(SET_MIN))      c_clamp = SET_MIN;
    else if (c_sum > (SET_W + 1)'(SET_MAX)) c_clamp = SET_MAX;
    else                                    c_clamp = c_sum[SET_W-1:0];
    if (g_sum < 7'sd0)                      g_clamp = '0;
    else if (g_sum > $signed({2'b00, GAIN_MAX})) g_clamp = GAIN_MAX;
    else                                    g_clamp = g_sum[GAIN_W-1:0];
    if (e_sum < 13'sd0)                     e_clamp = '0;
    else if (e_sum > $signed({2'b00, EXPO_MAX})) e_clamp = EXPO_MAX;
    else                                    e_clamp = e_sum[EXPO_W-1:0];
  end

  always_comb begin
    nxt = cur;
    unique case (issue)
      ISS_DARK: begin
        // brightness never reaches the flash cutoff, so flash always turns on
        nxt.flash = 1'b1;
        if (cur.expo < EXPO_MAX) begin
          nxt.expo = (expo_up > {1'b0, EXPO_MAX}) ? EXPO_MAX : expo_up[EXPO_W-1:0];
        end
        if (cur.bright < SET_MAX) nxt.bright = cur.bright + 3'sd1;
        if (cur.gain < GAIN_DARK_MAX) begin
          nxt.gain = (gain_up > {1'b0, GAIN_DARK_MAX}) ? GAIN_DARK_MAX
                                                      : gain_up[GAIN_W-1:0];
        end
      end
      ISS_BRIGHT: begin
        nxt.flash = 1'b0;
        if (cur.expo > EXPO_BRIGHT_MIN) begin
          if (cur.expo <= EXPO_BRIGHT_MIN + EXPO_DARK_STEP) nxt.expo = EXPO_BRIGHT_MIN;
          else if (cur.expo > EXPO_MAX + EXPO_DARK_STEP)    nxt.expo = EXPO_MAX;
          else                                              nxt.expo = cur.expo - EXPO_DARK_STEP;
        end
        if (cur.bright > SET_MIN) nxt.bright = cur.bright - 3'sd1;
        if (cur.gain > '0) begin
          if (cur.gain <= GAIN_DARK_STEP) begin
            nxt.gain = '0;
          end else if ({1'b0, cur.gain} > {1'b0, GAIN_MAX} + {1'b0, GAIN_DARK_STEP}) begin
            nxt.gain = GAIN_MAX;
          end else begin
            nxt.gain = cur.gain - GAIN_DARK_STEP;
          end
        end
      end
      ISS_CONTRAST: begin
        if (cur.contr < SET_MAX) nxt.contr = cur.contr + 3'sd1;
        if (cur.sharp < SET_MAX) nxt.sharp = cur.sharp + 3'sd1;
      end
      ISS_NOISE: begin
        if (cur.gain > '0) begin
          if (cur.gain <= GAIN_NOISE_STEP) begin
            nxt.gain = '0;
          end else if ({1'b0, cur.gain} > {1'b0, GAIN_MAX} + {1'b0, GAIN_NOISE_STEP}) begin
            nxt.gain = GAIN_MAX;
          end else begin
            nxt.gain = cur.gain - GAIN_NOISE_STEP;
          end
        end
        if (cur.expo < EXPO_NOISE_MAX) begin
          nxt.expo = (expo_nup > {1'b0, EXPO_NOISE_MAX}) ? EXPO_NOISE_MAX
                                                        : expo_nup[EXPO_W-1:0];
        end
      end
      default: begin
        unique case (rand_param)
          SEL_BRIGHT: nxt.bright = b_clamp;
          SEL_CONTR:  nxt.contr  = c_clamp;
          SEL_GAIN:   nxt.gain   = g_clamp;
          SEL_EXPO:   nxt.expo   = e_clamp;
          default:    nxt.expo   = e_clamp;
        endcase
      end
    endcase
  end

endmodule

// File: rtl/exposure_hill_climb_tuner_core.sv
// Exposure hill-climb tuner, top level: item register, run state, result register.
// Depends on ehc_pkg, ehc_classify and ehc_next_cand.
//
// Usage:
//  - Request channel (req_valid / req_stall): a start item (req_type 0) opens a
//    run and returns the stored best settings. Each metrics item (req_type 1)
//    scores the settings returned last and returns the next candidate, or the
//    best settings with done_res set once the run ends.
//  - Result channel (res_valid / res_stall): exactly one result per item, in
//    order. Each item passes the item register, then the result register;
//    a res_stall can hold it in the item register.
//  - Throughput is one item per cycle while res_stall is low: all run logic for
//    an item sits between the item and result registers, one 15x15 multiply deep.
//  - When res_stall holds a finished result, one more item may wait in the
//    item register; only then does req_stall rise.
//  - Config port (cfg_we, cfg_index, cfg_data): write only while idle.
//    Index 0 quality target, 1 min improvement, 2 iteration limit; index 3
//    is ignored.
//  - Reset (rst, synchronous): registers back to defaults, run idle, best
//    settings exposure 300 with everything else zero, no items in flight.
module exposure_hill_climb_tuner_core
  import ehc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [SCORE_W-1:0]        cfg_data,
  // request channel
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      req_type,
  input  logic                      is_dark,
  input  logic                      is_bright,
  input  logic [SCORE_W-1:0]        under_exposure,
  input  logic [SCORE_W-1:0]        over_exposure,
  input  logic [SCORE_W-1:0]        contrast_level,
  input  logic [SCORE_W-1:0]        noise_level,
  input  logic [SCORE_W-1:0]        frame_score,
  input  logic signed [1:0]         rand_step,
  input  logic [1:0]                rand_param,
  // result channel
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [SET_W-1:0]   brightness_out,
  output logic signed [SET_W-1:0]   contrast_out,
  output logic signed [SET_W-1:0]   sharpness_out,
  output logic [GAIN_W-1:0]         gain_out,
  output logic [EXPO_W-1:0]         exposure_out,
  output logic                      flash_out,
  output logic                      done_res,
  output logic                      converged,
  output logic [ITER_W-1:0]         iterations_used,
  output logic [SCORE_W-1:0]        best_score_out
);

  // configuration registers
  logic [SCORE_W-1:0] quality_target;
  logic [SCORE_W-1:0] min_improvement;
  logic [ITER_W-1:0]  max_iterations;

  // run state
  phase_t             run_phase, run_phase_next;
  logic [ITER_W-1:0]  iteration_count, iteration_count_next;
  cam_set_t           best_settings, best_settings_next;
  cam_set_t           candidate_settings, candidate_settings_next;
  logic [SCORE_W-1:0] best_score, best_score_next;
  issue_t             best_issue, best_issue_next;
  logic               converged_flag, converged_flag_next;

  // item register and handshake
  item_t              item;
  logic               item_valid;
  logic               item_ready;
  logic               res_ready;
  logic               fire;

  // per-item logic
  issue_t             frame_issue;
  cam_set_t           cand_gen;
  cam_set_t           res_set;
  logic               res_done;
  logic               metrics_path;
  logic               finish;
  logic               improved;
  logic               improve_small;
  logic [SCORE_W-1:0] score_diff;
  logic [PROD_W-1:0]  gain_lhs;
  logic [PROD_W-1:0]  gain_rhs;

  // Handshake: the result register drains first, the item register refills
  // behind it, so a stall on the result side costs one slot before req_stall.
  assign res_ready  = !res_valid || !res_stall;
  assign item_ready = !item_valid || res_ready;
  assign req_stall  = !item_ready;
  assign fire       = item_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_target  <= QUALITY_TARGET_RST;
      min_improvement <= MIN_IMPROVEMENT_RST;
      max_iterations  <= MAX_ITERATIONS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUALITY_TARGET:  quality_target  <= cfg_data;
        CFG_MIN_IMPROVEMENT: min_improvement <= cfg_data;
        CFG_MAX_ITERATIONS:  max_iterations  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_ready) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && req_valid) begin
      item.req_type               <= req_type;
      item.metrics.is_dark        <= is_dark;
      item.metrics.is_bright      <= is_bright;
      item.metrics.under_exposure <= under_exposure;
      item.metrics.over_exposure  <= over_exposure;
      item.metrics.contrast_level <= contrast_level;
      item.metrics.noise_level    <= noise_level;
      item.frame_score            <= frame_score;
      item.rand_step              <= rand_step;
      item.rand_param             <= rand_param;
    end
  end

  ehc_classify u_classify (
    .metrics (item.metrics),
    .issue   (frame_issue)
  );

  // Small-gain test, cross-multiplied: (new - old) * 100% < min_improvement * old.
  // Only looked at when the new score beats the old one, so the diff is positive.
  assign improved   = item.frame_score > best_score;
  assign score_diff = item.frame_score - best_score;
  assign gain_lhs   = PROD_W'(score_diff) * IMPROVE_SCALE;
  assign gain_rhs   = PROD_W'(min_improvement) * PROD_W'(best_score);
  assign improve_small = gain_lhs < gain_rhs;

  // Best-frame bookkeeping; feeds the candidate generator below.
  always_comb begin
    best_settings_next  = best_settings;
    best_score_next     = best_score;
    best_issue_next     = best_issue;
    converged_flag_next = converged_flag;
    metrics_path        = 1'b0;
    finish              = 1'b0;
    if (item.req_type == REQ_START) begin
      converged_flag_next = 1'b0;
    end else begin
      unique case (run_phase)
        PH_FIRST: begin
          // first frame of a run scores the stored settings outright
          best_score_next = item.frame_score;
          best_issue_next = frame_issue;
          metrics_path    = 1'b1;
        end
        PH_ITER: begin
          metrics_path = 1'b1;
          if (improved) begin
            best_score_next    = item.frame_score;
            best_settings_next = candidate_settings;
            best_issue_next    = frame_issue;
            if (item.frame_score >= quality_target) begin
              converged_flag_next = 1'b1;
              finish              = 1'b1;
            end else if (improve_small) begin
              converged_flag_next = 1'b1;
              finish              = 1'b1;
            end
          end
        end
        PH_IDLE, PH_DONE: ;
        default: ;
      endcase
      // iteration limit, also catches a limit lowered mid-run
      if (metrics_path && iteration_count >= max_iterations) begin
        finish = 1'b1;
      end
    end
  end

  ehc_next_cand u_next_cand (
    .cur        (best_settings_next),
    .issue      (best_issue_next),
    .rand_step  (item.rand_step),
    .rand_param (item.rand_param),
    .nxt        (cand_gen)
  );

  // Phase, count, candidate and the settings handed out with this item.
  always_comb begin
    run_phase_next          = run_phase;
    iteration_count_next    = iteration_count;
    candidate_settings_next = candidate_settings;
    res_set                 = best_settings_next;
    res_done                = 1'b0;
    if (item.req_type == REQ_START) begin
      run_phase_next          = PH_FIRST;
      iteration_count_next    = '0;
      candidate_settings_next = best_settings;
    end else if (metrics_path) begin
      if (finish) begin
        run_phase_next = PH_DONE;
        res_done       = 1'b1;
      end else begin
        run_phase_next          = PH_ITER;
        iteration_count_next    = iteration_count + ITER_W'(1);
        candidate_settings_next = cand_gen;
        res_set                 = cand_gen;
      end
    end else begin
      // metrics outside a run: ignored, report what is stored
      res_done = (run_phase == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_phase          <= PH_IDLE;
      iteration_count    <= '0;
      best_settings      <= SET_RESET;
      candidate_settings <= SET_RESET;
      best_score         <= '0;
      best_issue         <= ISS_NONE;
      converged_flag     <= 1'b0;
    end else if (fire) begin
      run_phase          <= run_phase_next;
      iteration_count    <= iteration_count_next;
      best_settings      <= best_settings_next;
      candidate_settings <= candidate_settings_next;
      best_score         <= best_score_next;
      best_issue         <= best_issue_next;
      converged_flag     <= converged_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      brightness_out  <= res_set.bright;
      contrast_out    <= res_set.contr;
      sharpness_out   <= res_set.sharp;
      gain_out        <= res_set.gain;
      exposure_out    <= res_set.expo;
      flash_out       <= res_set.flash;
      done_res        <= res_done;
      converged       <= converged_flag_next;
      iterations_used <= iteration_count_next;
      best_score_out  <= best_score_next;
    end
  end

  // a finished run is the only phase a converged flag can live in
  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    converged_flag |-> run_phase == PH_DONE)
    else $error("converged flag set outside finished phase");

  // a shown done result matches the stored phase until the next item moves
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> run_phase == PH_DONE)
    else $error("done result without finished phase");

  // best score only climbs, except when the first frame of a run rescores it
  a_score_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(run_phase) != PH_FIRST |-> best_score >= $past(best_score))
    else $error("best score went down");

  // a start clears the count and the converged flag
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type == REQ_START |=> iteration_count == '0 && !converged_flag)
    else $error("start did not clear run counters");

  // stall only with an item held back
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> item_valid && res_valid)
    else $error("request stalled with free space");

endmodule

// File: bench/tb_exposure_hill_climb_tuner_core.sv
`timescale 1ns / 100ps
// Self-checking bench for exposure_hill_climb_tuner_core: directed and random tuning runs,
// every result checked against an in-bench prediction of the hill-climb state.
// Depends on ehc_pkg and the core RTL; reads no files.
module tb_exposure_hill_climb_tuner_core;
  import ehc_pkg::*;

  // One predicted result item.
  typedef struct {
    cam_set_t           cam;
    logic               done;
    logic               settled;
    logic [ITER_W-1:0]  count;
    logic [SCORE_W-1:0] score;
  } tuner_out_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [SCORE_W-1:0]      cfg_data;
  logic                    req_valid;
  logic                    req_stall;
  logic                    req_type;
  logic                    is_dark;
  logic                    is_bright;
  logic [SCORE_W-1:0]      under_exposure;
  logic [SCORE_W-1:0]      over_exposure;
  logic [SCORE_W-1:0]      contrast_level;
  logic [SCORE_W-1:0]      noise_level;
  logic [SCORE_W-1:0]      frame_score;
  logic signed [1:0]       rand_step;
  logic [1:0]              rand_param;
  logic                    res_valid;
  logic                    res_stall;
  logic signed [SET_W-1:0] brightness_out;
  logic signed [SET_W-1:0] contrast_out;
  logic signed [SET_W-1:0] sharpness_out;
  logic [GAIN_W-1:0]       gain_out;
  logic [EXPO_W-1:0]       exposure_out;
  logic                    flash_out;
  logic                    done_res;
  logic                    converged;
  logic [ITER_W-1:0]       iterations_used;
  logic [SCORE_W-1:0]      best_score_out;

  // Predicted tuner registers and run state.
  logic [SCORE_W-1:0] target_reg;
  logic [SCORE_W-1:0] min_gain_reg;
  logic [ITER_W-1:0]  limit_reg;
  phase_t             run_state;
  logic [ITER_W-1:0]  eval_count;
  cam_set_t           kept_set;    // best settings so far
  cam_set_t           trial_set;   // settings handed out last, scored by the next frame
  logic [SCORE_W-1:0] kept_score;
  issue_t             kept_issue;
  logic               settled;

  tuner_out_t tuner_outputs_due[$];  // predicted results, oldest first
  int         errors;
  bit         idling_on;
  int         stall_left;
  int         quiet_left;

  exposure_hill_climb_tuner_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_type        (req_type),
    .is_dark         (is_dark),
    .is_bright       (is_bright),
    .under_exposure  (under_exposure),
    .over_exposure   (over_exposure),
    .contrast_level  (contrast_level),
    .noise_level     (noise_level),
    .frame_score     (frame_score),
    .rand_step       (rand_step),
    .rand_param      (rand_param),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .brightness_out  (brightness_out),
    .contrast_out    (contrast_out),
    .sharpness_out   (sharpness_out),
    .gain_out        (gain_out),
    .exposure_out    (exposure_out),
    .flash_out       (flash_out),
    .done_res        (done_res),
    .converged       (converged),
    .iterations_used (iterations_used),
    .best_score_out  (best_score_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run (~1k items with full stalls and gaps).
  initial begin
    #2_000_000;
    $display("tb_exposure_hill_climb_tuner_core failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void reset_tuner_model();
    target_reg   = 15'd19200;
    min_gain_reg = 15'd512;
    limit_reg    = 8'd10;
    run_state    = PH_IDLE;
    eval_count   = '0;
    kept_set     = '{bright: 3'sd0, contr: 3'sd0, sharp: 3'sd0, gain: 5'd0,
                     expo: 11'd300, flash: 1'b0};
    trial_set    = kept_set;
    kept_score   = '0;
    kept_issue   = ISS_NONE;
    settled      = 1'b0;
  endfunction

  function automatic int limit_to(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Main problem of a frame, highest priority first.
  function automatic issue_t find_issue(metrics_t m);
    if (m.is_dark || m.under_exposure > 15'd3840) return ISS_DARK;
    if (m.is_bright || m.over_exposure > 15'd2560) return ISS_BRIGHT;
    if (m.contrast_level < 15'd7680) return ISS_CONTRAST;
    if (m.noise_level > 15'd7680) return ISS_NOISE;
    return ISS_NONE;
  endfunction

  // Next candidate: fix for the issue, or a random neighbor step when there is none.
  function automatic cam_set_t adjust_settings(cam_set_t s, issue_t issue,
                                               logic signed [1:0] dir, logic [1:0] pick);
    int       b;
    int       c;
    int       sh;
    int       g;
    int       e;
    int       d;
    logic     f;
    cam_set_t n;
    b  = $signed(s.bright);
    c  = $signed(s.contr);
    sh = $signed(s.sharp);
    g  = s.gain;
    e  = s.expo;
    f  = s.flash;
    d  = dir;
    case (issue)
      ISS_DARK: begin
        f = 1'b1;  // brightness never gets near the flash cutoff
        if (e < 1200) e = limit_to(e + 200, 0, 1200);
        if (b < 2) b++;
        if (g < 20) g = limit_to(g + 5, 0, 20);
      end
      ISS_BRIGHT: begin
        f = 1'b0;
        if (e > 100) e = limit_to(e - 200, 100, 1200);
        if (b > -2) b--;
        if (g > 0) g = limit_to(g - 5, 0, 30);
      end
      ISS_CONTRAST: begin
        if (c < 2) c++;
        if (sh < 2) sh++;
      end
      ISS_NOISE: begin
        if (g > 0) g = limit_to(g - 3, 0, 30);
        if (e < 800) e = limit_to(e + 100, 0, 800);
      end
      default: begin
        case (pick)
          SEL_BRIGHT: b = limit_to(b + d, -2, 2);
          SEL_CONTR:  c = limit_to(c + d, -2, 2);
          SEL_GAIN:   g = limit_to(g + d * 3, 0, 30);
          default:    e = limit_to(e + d * 50, 0, 1200);
        endcase
      end
    endcase
    n.bright = b[SET_W-1:0];
    n.contr  = c[SET_W-1:0];
    n.sharp  = sh[SET_W-1:0];
    n.gain   = g[GAIN_W-1:0];
    n.expo   = e[EXPO_W-1:0];
    n.flash  = f;
    return n;
  endfunction

  function automatic void expect_output(cam_set_t cam, logic done);
    tuner_out_t r;
    r.cam     = cam;
    r.done    = done;
    r.settled = settled;
    r.count   = eval_count;
    r.score   = kept_score;
    tuner_outputs_due.push_back(r);
  endfunction

  // Applies one accepted item to the predicted state and queues its result.
  function automatic void advance_tuner(item_t it);
    logic               finish;
    logic [SCORE_W-1:0] prev_score;
    int                 gain_num;
    finish = 1'b0;
    if (it.req_type == REQ_START) begin
      // restart from any phase; the kept score survives until the first frame
      run_state  = PH_FIRST;
      eval_count = '0;
      settled    = 1'b0;
      trial_set  = kept_set;
      expect_output(kept_set, 1'b0);
      return;
    end
    case (run_state)
      PH_FIRST: begin
        kept_score = it.frame_score;
        kept_issue = find_issue(it.metrics);
      end
      PH_ITER: begin
        if (it.frame_score > kept_score) begin
          prev_score = kept_score;
          kept_score = it.frame_score;
          kept_set   = trial_set;
          kept_issue = find_issue(it.metrics);
          gain_num   = kept_score - prev_score;
          if (kept_score >= target_reg) begin
            settled = 1'b1;
            finish  = 1'b1;
          end else if (longint'(gain_num) * 25600 <
                       longint'(min_gain_reg) * longint'(prev_score)) begin
            // relative gain too small; never true from a zero score
            settled = 1'b1;
            finish  = 1'b1;
          end
        end
      end
      default: begin
        // metrics with no run open are ignored
        expect_output(kept_set, run_state == PH_DONE);
        return;
      end
    endcase
    if (!finish && eval_count >= limit_reg) finish = 1'b1;
    if (finish) begin
      run_state = PH_DONE;
      expect_output(kept_set, 1'b1);
      return;
    end
    eval_count = eval_count + 1'b1;
    trial_set  = adjust_settings(kept_set, kept_issue, it.rand_step, it.rand_param);
    run_state  = PH_ITER;
    expect_output(trial_set, 1'b0);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, then compare against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!idling_on) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      res_stall <= 1'b0;
      quiet_left--;
    end else if ($urandom_range(0, 1) == 0) begin
      res_stall <= 1'b1;               // start a stall burst of random length
      stall_left = $urandom_range(0, 11);
    end else begin
      res_stall <= 1'b0;               // quiet stretch, sometimes long
      quiet_left = $urandom_range(0, 40);
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    tuner_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (tuner_outputs_due.size() == 0) begin
        $display("%0t: result item with none expected, expected nothing, got exposure %0d",
                 $time, exposure_out);
        errors++;
      end else begin
        want = tuner_outputs_due.pop_front();
        compare_field("brightness_out", $signed(want.cam.bright), $signed(brightness_out));
        compare_field("contrast_out", $signed(want.cam.contr), $signed(contrast_out));
        compare_field("sharpness_out", $signed(want.cam.sharp), $signed(sharpness_out));
        compare_field("gain_out", want.cam.gain, gain_out);
        compare_field("exposure_out", want.cam.expo, exposure_out);
        compare_field("flash_out", want.cam.flash, flash_out);
        compare_field("done_res", want.done, done_res);
        compare_field("converged", want.settled, converged);
        compare_field("iterations_used", want.count, iterations_used);
        compare_field("best_score_out", want.score, best_score_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item generation and driving
  // ---------------------------------------------------------------------------

  // Metrics item shaped so that the frame's main issue is the one aimed for.
  // Fields below the deciding one take their full 15-bit range.
  function automatic item_t frame_item(issue_t aim, int score);
    item_t it;
    it.req_type                = REQ_METRICS;
    it.metrics.is_dark         = 1'b0;
    it.metrics.is_bright       = 1'b0;
    it.metrics.under_exposure  = 15'($urandom_range(0, 3840));
    it.metrics.over_exposure   = 15'($urandom_range(0, 2560));
    it.metrics.contrast_level  = 15'($urandom_range(7680, 32767));
    it.metrics.noise_level     = 15'($urandom_range(0, 7680));
    case (aim)
      ISS_DARK: begin
        if ($urandom_range(0, 1) == 0) it.metrics.is_dark = 1'b1;
        else it.metrics.under_exposure = 15'($urandom_range(3841, 32767));
        it.metrics.is_bright      = 1'($urandom);
        it.metrics.over_exposure  = 15'($urandom);
        it.metrics.contrast_level = 15'($urandom);
        it.metrics.noise_level    = 15'($urandom);
      end
      ISS_BRIGHT: begin
        if ($urandom_range(0, 1) == 0) it.metrics.is_bright = 1'b1;
        else it.metrics.over_exposure = 15'($urandom_range(2561, 32767));
        it.metrics.contrast_level = 15'($urandom);
        it.metrics.noise_level    = 15'($urandom);
      end
      ISS_CONTRAST: begin
        it.metrics.contrast_level = 15'($urandom_range(0, 7679));
        it.metrics.noise_level    = 15'($urandom);
      end
      ISS_NOISE: it.metrics.noise_level = 15'($urandom_range(7681, 32767));
      default: ;
    endcase
    it.frame_score = 15'(score);
    it.rand_step   = 2'($urandom);
    it.rand_param  = 2'($urandom);
    return it;
  endfunction

  function automatic item_t start_item();
    item_t it;
    it          = frame_item(issue_t'($urandom_range(0, 4)), $urandom_range(0, 32767));
    it.req_type = REQ_START;
    return it;
  endfunction

  // Scores around the kept one, so runs see both small and large gains.
  function automatic int pick_score();
    int s;
    case ($urandom_range(0, 9))
      0:       s = 0;
      1:       s = kept_score;
      2:       s = int'(kept_score) - int'($urandom_range(0, 200));
      3, 4:    s = int'(kept_score) + int'($urandom_range(1, 40));
      5, 6, 7: s = int'(kept_score) + int'($urandom_range(1, 3000));
      8:       s = int'(target_reg) + int'($urandom_range(0, 2)) - 1;
      default: s = $urandom_range(0, 32767);
    endcase
    return limit_to(s, 0, 32767);
  endfunction

  function automatic item_t random_frame();
    return frame_item(issue_t'($urandom_range(0, 4)), pick_score());
  endfunction

  // Drives one item and holds it until accepted; returns on the accepting edge.
  task automatic send_item(input item_t it);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid      <= 1'b1;
    req_type       <= it.req_type;
    is_dark        <= it.metrics.is_dark;
    is_bright      <= it.metrics.is_bright;
    under_exposure <= it.metrics.under_exposure;
    over_exposure  <= it.metrics.over_exposure;
    contrast_level <= it.metrics.contrast_level;
    noise_level    <= it.metrics.noise_level;
    frame_score    <= it.frame_score;
    rand_step      <= it.rand_step;
    rand_param     <= it.rand_param;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_tuner(it);
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (tuner_outputs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // covers the item and result registers
  endtask

  // Writes all three registers back to back while nothing is in flight.
  task automatic set_tuning(input int target, input int min_gain, input int limit);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUALITY_TARGET;
    cfg_data  <= 15'(target);
    @(posedge clk);
    cfg_index <= CFG_MIN_IMPROVEMENT;
    cfg_data  <= 15'(min_gain);
    @(posedge clk);
    cfg_index <= CFG_MAX_ITERATIONS;
    cfg_data  <= 15'(limit);
    @(posedge clk);
    cfg_we       <= 1'b0;
    target_reg   = 15'(target);
    min_gain_reg = 15'(min_gain);
    limit_reg    = 8'(limit);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ignored item while idle, then one fix per issue type with the thresholds hit
  // exactly, the neighbor steps over all four choices, and an all-ones frame.
  task automatic test_issue_steps();
    item_t it;
    it          = '0;
    it.req_type = REQ_METRICS;
    send_item(it);
    send_item(start_item());
    // first frame scores zero and is dark just past the threshold
    it = frame_item(ISS_NONE, 0);
    it.metrics.under_exposure = 15'd3841;
    send_item(it);
    // gain from a zero score is never judged small
    it = frame_item(ISS_NONE, 1);
    it.metrics.over_exposure = 15'd2561;
    send_item(it);
    it = frame_item(ISS_NONE, 300);
    it.metrics.contrast_level = 15'd7679;
    send_item(it);
    it = frame_item(ISS_NONE, 400);
    it.metrics.noise_level = 15'd7681;
    send_item(it);
    // no issue, every metric on its threshold; step patterns -2, -1, 0, +1
    for (int k = 0; k < 4; k++) begin
      it = frame_item(ISS_NONE, 500 + 100 * k);
      it.metrics.under_exposure = 15'd3840;
      it.metrics.over_exposure  = 15'd2560;
      it.metrics.contrast_level = 15'd7680;
      it.metrics.noise_level    = 15'd7680;
      it.rand_step              = 2'(k + 2);
      it.rand_param             = 2'(k);
      send_item(it);
    end
    it = '1;
    send_item(it);          // reaches the target
    send_item(random_frame());  // ignored once finished
  endtask

  // Start in the finished phase and again in the middle of a run.
  task automatic test_restart();
    send_item(start_item());
    send_item(random_frame());
    send_item(start_item());
    send_item(random_frame());
    send_item(random_frame());
  endtask

  // Iteration limit of zero: finished, not converged, on the first frame.
  task automatic test_zero_limit();
    set_tuning(25600, 25600, 0);
    send_item(start_item());
    send_item(random_frame());
    send_item(random_frame());
  endtask

  // A 50 percent gain is below a 100 percent threshold.
  task automatic test_small_gain();
    set_tuning(25600, 25600, 255);
    send_item(start_item());
    send_item(frame_item(ISS_DARK, 1000));
    send_item(frame_item(ISS_NONE, 1500));
  endtask

  // Mostly whole runs with random content, some cut short by a fresh start,
  // and stray metrics items in between.
  task automatic random_runs(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) send_item(random_frame());
      send_item(start_item());
      sent++;
      while (run_state != PH_DONE && sent < count) begin
        send_item(random_frame());
        sent++;
        if ($urandom_range(0, 39) == 0) break;
      end
      if (idling_on && $urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_QUALITY_TARGET;
    cfg_data       = '0;
    req_valid      = 1'b0;
    req_type       = REQ_START;
    is_dark        = 1'b0;
    is_bright      = 1'b0;
    under_exposure = '0;
    over_exposure  = '0;
    contrast_level = '0;
    noise_level    = '0;
    frame_score    = '0;
    rand_step      = '0;
    rand_param     = '0;
    res_stall      = 1'b0;
    errors         = 0;
    idling_on      = 1'b1;
    stall_left     = 0;
    quiet_left     = 0;
    reset_tuner_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values first
    test_issue_steps();
    test_restart();
    test_zero_limit();
    test_small_gain();

    // random phases across register settings, extremes included
    set_tuning(19200, 512, 10);
    random_runs(250);
    set_tuning(25600, 0, 255);
    random_runs(200);
    set_tuning(0, 25600, 1);
    random_runs(100);
    set_tuning($urandom_range(0, 25600), $urandom_range(0, 25600), $urandom_range(0, 255));
    idling_on = 1'b0;  // last stretch at full rate on both sides
    random_runs(200);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_exposure_hill_climb_tuner_core passed");
    end else begin
      $display("tb_exposure_hill_climb_tuner_core failed");
    end
    $finish;
  end

endmodule
